// ----- hdl/rledec_pkg.sv -----
// ----------------------------------------------------------------------------
// rledec_pkg
// Shared types and constants of the dual format run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rledec_pkg;

   localparam int SYMBOL_BITS = 16;
   localparam int VALUE_BITS  = 16;
   localparam int RUN_BITS    = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int HDR_REPEAT_BIT = 7;
   localparam int HDR_WIDE_BIT   = 6;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_COUNT   = 4'b0010,
      PH_REPEAT  = 4'b0100,
      PH_LITERAL = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [RUN_BITS-1:0]   run_length;
      logic                  from_repeat;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/rledec_front.sv -----
// ----------------------------------------------------------------------------
// rledec_front
// Classifies each coded symbol as selector, header, count byte or data symbol
// and turns data symbols into run descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module rledec_front (
   input  wire                                logic clock,
   input  wire                                logic reset,
   input  wire                                logic accept,
   input  wire logic [rledec_pkg::SYMBOL_BITS-1:0] symbol,
   input  wire                                logic stream_start,
   output                                     logic res_valid,
   output rledec_pkg::rsp_type                      res
);
   import rledec_pkg::*;

   phase_type           phase_ff, phase_in;
   logic                long_ff, long_in;
   logic                repeat_ff, repeat_in;
   logic [5:0]          count_high_ff, count_high_in;
   logic [RUN_BITS-1:0] left_ff, left_in;

   logic [7:0]          hdr;
   logic                hdr_rep;
   logic [RUN_BITS-1:0] offset;
   logic [RUN_BITS-1:0] left_dec;

   assign hdr      = symbol[7:0];
   assign hdr_rep  = hdr[HDR_REPEAT_BIT];
   assign offset   = hdr_rep ? RUN_BITS'(2) : RUN_BITS'(1);
   assign left_dec = left_ff - RUN_BITS'(1);

   always_comb begin
      phase_in       = phase_ff;
      long_in        = long_ff;
      repeat_in      = repeat_ff;
      count_high_in  = count_high_ff;
      left_in        = left_ff;
      res_valid      = 1'b0;
      res.value      = VALUE_BITS'(symbol);
      res.run_length = RUN_BITS'(1);
      res.from_repeat = 1'b0;
      if (accept) begin
         if (stream_start) begin
            long_in       = (symbol != '0);
            phase_in      = PH_HEADER;
            repeat_in     = 1'b0;
            count_high_in = '0;
            left_in       = '0;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  repeat_in = hdr_rep;
                  if (!long_ff) begin
                     left_in  = RUN_BITS'(hdr[6:0]) + offset;
                     phase_in = hdr_rep ? PH_REPEAT : PH_LITERAL;
                  end else if (hdr[HDR_WIDE_BIT]) begin
                     count_high_in = hdr[5:0];
                     phase_in      = PH_COUNT;
                  end else begin
                     left_in  = RUN_BITS'(hdr[5:0]) + offset;
                     phase_in = hdr_rep ? PH_REPEAT : PH_LITERAL;
                  end
               end
               PH_COUNT: begin
                  left_in  = {1'b0, count_high_ff, hdr}
                             + (repeat_ff ? RUN_BITS'(2) : RUN_BITS'(1));
                  phase_in = repeat_ff ? PH_REPEAT : PH_LITERAL;
               end
               PH_REPEAT: begin
                  res_valid       = 1'b1;
                  res.run_length  = left_ff;
                  res.from_repeat = 1'b1;
                  left_in         = '0;
                  phase_in        = PH_HEADER;
               end
               PH_LITERAL: begin
                  res_valid = 1'b1;
                  left_in   = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_HEADER;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         long_ff       <= 1'b0;
         repeat_ff     <= 1'b0;
         count_high_ff <= '0;
         left_ff       <= '0;
      end else begin
         phase_ff      <= phase_in;
         long_ff       <= long_in;
         repeat_ff     <= repeat_in;
         count_high_ff <= count_high_in;
         left_ff       <= left_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rledec_queue.sv -----
// ----------------------------------------------------------------------------
// rledec_queue
// Short register queue that holds run descriptors until the consumer takes
// them.
// ----------------------------------------------------------------------------
`default_nettype none

module rledec_queue (
   input  wire                 logic clock,
   input  wire                 logic reset,
   input  wire                 logic push,
   input  wire rledec_pkg::rsp_type  din,
   output                      logic full,
   input  wire                 logic pop,
   output                      logic empty,
   output rledec_pkg::rsp_type       dout
);
   import rledec_pkg::*;

   rsp_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dual_format_rle_decoder_core.sv -----
// ----------------------------------------------------------------------------
// dual_format_rle_decoder_core
// Run-length decoder for a two-format PackBits-style code; emits one run
// descriptor per repeat run and one per literal symbol.
// ----------------------------------------------------------------------------
// A descriptor is written into the queue as its data symbol transfers in and
//    can show on the rsp ports from the next cycle.
// Throughput: one symbol per cycle while not full; the four-entry descriptor
//    queue sets how long the input keeps going while the consumer stalls.
// Reset clears the decoder state (short format, header expected) and the queue.
`default_nettype none

module dual_format_rle_decoder_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output      logic                               req_full,
   input  wire logic [rledec_pkg::SYMBOL_BITS-1:0] req_symbol,
   input  wire logic                               req_stream_start,
   output      logic                               rsp_empty,
   input  wire logic                               rsp_pop,
   output      logic [rledec_pkg::VALUE_BITS-1:0]  rsp_value,
   output      logic [rledec_pkg::RUN_BITS-1:0]    rsp_run_length,
   output      logic                               rsp_from_repeat
);
   import rledec_pkg::*;

   logic    accept;
   logic    res_valid;
   rsp_type res;
   rsp_type head;

   assign accept = req_push && !req_full;

   rledec_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .symbol       (req_symbol),
      .stream_start (req_stream_start),
      .res_valid    (res_valid),
      .res          (res)
   );

   rledec_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .din   (res),
      .full  (req_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (head)
   );

   assign rsp_value       = head.value;
   assign rsp_run_length  = head.run_length;
   assign rsp_from_repeat = head.from_repeat;

endmodule

`default_nettype wire

// ----- hdl/rledec_checker.sv -----
// ----------------------------------------------------------------------------
// rledec_checker
// Port-level checks of the run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rledec_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_push,
   input wire logic                               req_full,
   input wire logic                               req_stream_start,
   input wire logic                               rsp_empty,
   input wire logic [rledec_pkg::RUN_BITS-1:0]    rsp_run_length,
   input wire logic                               rsp_from_repeat
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("queue not empty after reset");

   a_result_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_empty) |-> $past(req_push && !req_full)))
      else $error("result appeared without an input transfer");

   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_stream_start && rsp_empty |=> rsp_empty))
      else $error("stream start produced a result");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty |-> rsp_run_length != '0))
      else $error("zero run length");

   a_literal_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_from_repeat |-> rsp_run_length == 15'd1))
      else $error("literal with run length other than one");

endmodule

bind dual_format_rle_decoder_core rledec_checker u_rledec_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .req_stream_start (req_stream_start),
   .rsp_empty        (rsp_empty),
   .rsp_run_length   (rsp_run_length),
   .rsp_from_repeat  (rsp_from_repeat)
);

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_format_rle_decoder_core. Symbols are pushed
// through the request queue port and the run descriptors popped from the
// response side are checked against a cycle-free decoder kept in the bench.
// The run covers directed corner streams, back-pressure and pauses, and
// random streams of both formats under three idling profiles.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rledec_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 10;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [SYMBOL_BITS-1:0] req_symbol;
   logic                   req_stream_start;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [VALUE_BITS-1:0]  rsp_value;
   logic [RUN_BITS-1:0]    rsp_run_length;
   logic                   rsp_from_repeat;

   // decoder state of the bench
   logic                   fmt_long;
   phase_type              dec_phase;
   logic                   rep_flag;
   logic [5:0]             cnt_high;
   logic [RUN_BITS-1:0]    lit_left;

   rsp_type                expected_runs[$];
   rsp_type                head_run;
   int                     n_errors   = 0;
   int                     n_symbols  = 0;
   int                     snd_idle   = 0;
   int                     rcv_idle   = 0;
   int                     hold_req   = 0;
   int                     hold_left  = 0;
   int                     idle_count = 0;

   dual_format_rle_decoder_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_symbol       (req_symbol),
      .req_stream_start (req_stream_start),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_value        (rsp_value),
      .rsp_run_length   (rsp_run_length),
      .rsp_from_repeat  (rsp_from_repeat)
   );

   always #5 clock = ~clock;

   task automatic decoder_reset();
      fmt_long  = 1'b0;
      dec_phase = PH_HEADER;
      rep_flag  = 1'b0;
      cnt_high  = '0;
      lit_left  = '0;
   endtask

   task automatic decode_symbol(input logic [SYMBOL_BITS-1:0] sym, input logic ss);
      logic [7:0] h;
      rsp_type    run;
      h = sym[7:0];
      if (ss) begin
         decoder_reset();
         fmt_long = (sym != '0);
      end else begin
         case (dec_phase)
            PH_HEADER: begin
               rep_flag = h[7];
               if (!fmt_long) begin
                  lit_left  = RUN_BITS'(h[6:0]) + (rep_flag ? 15'd2 : 15'd1);
                  dec_phase = rep_flag ? PH_REPEAT : PH_LITERAL;
               end else if (h[6]) begin
                  cnt_high  = h[5:0];
                  dec_phase = PH_COUNT;
               end else begin
                  lit_left  = RUN_BITS'(h[5:0]) + (rep_flag ? 15'd2 : 15'd1);
                  dec_phase = rep_flag ? PH_REPEAT : PH_LITERAL;
               end
            end
            PH_COUNT: begin
               lit_left  = RUN_BITS'({cnt_high, h}) + (rep_flag ? 15'd2 : 15'd1);
               dec_phase = rep_flag ? PH_REPEAT : PH_LITERAL;
            end
            PH_REPEAT: begin
               run.value       = VALUE_BITS'(sym);
               run.run_length  = lit_left;
               run.from_repeat = 1'b1;
               expected_runs.insert(expected_runs.size(), run);
               lit_left  = '0;
               dec_phase = PH_HEADER;
            end
            default: begin
               run.value       = VALUE_BITS'(sym);
               run.run_length  = 15'd1;
               run.from_repeat = 1'b0;
               expected_runs.insert(expected_runs.size(), run);
               lit_left = lit_left - 15'd1;
               if (lit_left == '0)
                  dec_phase = PH_HEADER;
            end
         endcase
      end
   endtask

   task automatic send_symbol(input logic [SYMBOL_BITS-1:0] sym, input logic ss);
      while ($urandom_range(0, 99) < snd_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_symbol       <= sym;
      req_stream_start <= ss;
      do @(posedge clock); while (req_full);
      decode_symbol(sym, ss);
      n_symbols++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_runs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      // short format before any selector
      send_symbol(16'h0085, 1'b0);
      send_symbol(16'hFFFF, 1'b0);
      send_symbol(16'hFF01, 1'b0);
      send_symbol(16'h0000, 1'b0);
      send_symbol(16'h8001, 1'b0);
      send_symbol(16'h00FF, 1'b0);
      send_symbol(16'h5A5A, 1'b0);
      send_symbol(16'h0080, 1'b0);
      send_symbol(16'h0001, 1'b0);
      // long format, longest repeat
      send_symbol(16'h0100, 1'b1);
      send_symbol(16'h00FF, 1'b0);
      send_symbol(16'hFFFF, 1'b0);
      send_symbol(16'hABCD, 1'b0);
      send_symbol(16'h0040, 1'b0);
      send_symbol(16'h1201, 1'b0);
      send_symbol(16'h7FFF, 1'b0);
      send_symbol(16'h8000, 1'b0);
      send_symbol(16'h00BF, 1'b0);
      send_symbol(16'h1111, 1'b0);
      send_symbol(16'h00C0, 1'b0);
      send_symbol(16'h0000, 1'b0);
      send_symbol(16'h3333, 1'b0);
      // cut a long literal run and a pending repeat short
      send_symbol(16'h007F, 1'b0);
      send_symbol(16'h00FF, 1'b0);
      send_symbol(16'h4444, 1'b0);
      send_symbol(16'h0000, 1'b1);
      send_symbol(16'h0085, 1'b0);
      send_symbol(16'hFFFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_req = HOLD_CYCLES;
      send_symbol(16'h0000, 1'b1);
      send_symbol(16'h0013, 1'b0);
      repeat (20) send_symbol(SYMBOL_BITS'($urandom_range(0, 65535)), 1'b0);
      wait_drained();
   endtask

   task automatic random_stream();
      int          runs;
      int          n;
      logic        rep;
      logic        wide;
      logic [5:0]  hi;
      logic [7:0]  h;
      logic [7:0]  lo;
      send_symbol($urandom_range(0, 1) ? SYMBOL_BITS'($urandom_range(0, 65535)) : '0, 1'b1);
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs; r++) begin
         rep = $urandom_range(0, 1);
         if (!fmt_long) begin
            h = {rep, 7'((rep || $urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 7))};
            send_symbol({8'($urandom), h}, 1'b0);
         end else begin
            wide = $urandom_range(0, 1);
            if (wide) begin
               hi = 6'((rep || $urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : 0);
               lo = 8'((rep || $urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 15));
               send_symbol({8'($urandom), rep, 1'b1, hi}, 1'b0);
               send_symbol({8'($urandom), lo}, 1'b0);
            end else begin
               hi = 6'(rep ? $urandom_range(0, 63) : $urandom_range(0, 7));
               send_symbol({8'($urandom), rep, 1'b0, hi}, 1'b0);
            end
         end
         if (dec_phase == PH_REPEAT) begin
            if ($urandom_range(0, 99) < 5)
               return;
            send_symbol(SYMBOL_BITS'($urandom_range(0, 65535)), 1'b0);
         end else begin
            n = lit_left;
            if (n > 300 || $urandom_range(0, 99) < 5) begin
               n = $urandom_range(0, (n < 3) ? n - 1 : 3);
               repeat (n) send_symbol(SYMBOL_BITS'($urandom_range(0, 65535)), 1'b0);
               return;
            end
            repeat (n) send_symbol(SYMBOL_BITS'($urandom_range(0, 65535)), 1'b0);
         end
      end
   endtask

   task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
      int target;
      snd_idle = snd_pct;
      rcv_idle = rcv_pct;
      target   = n_symbols + n_items;
      while (n_symbols < target) begin
         if ($urandom_range(0, 99) < 5)
            send_symbol(SYMBOL_BITS'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
         else
            random_stream();
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_left  = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected descriptor value=%h run_length=%0d from_repeat=%b",
                      rsp_value, rsp_run_length, rsp_from_repeat);
               n_errors++;
            end else begin
               head_run = expected_runs.pop_front();
               if (rsp_value !== head_run.value) begin
                  $error("value: expected %h actual %h", head_run.value, rsp_value);
                  n_errors++;
               end
               if (rsp_run_length !== head_run.run_length) begin
                  $error("run_length: expected %0d actual %0d",
                         head_run.run_length, rsp_run_length);
                  n_errors++;
               end
               if (rsp_from_repeat !== head_run.from_repeat) begin
                  $error("from_repeat: expected %b actual %b",
                         head_run.from_repeat, rsp_from_repeat);
                  n_errors++;
               end
            end
         end
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rcv_idle);
         end
      end
   end

   initial begin
      while (idle_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_count = 0;
         else
            idle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_symbol       <= '0;
      req_stream_start <= 1'b0;
      decoder_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle = 18;
      rcv_idle = 72;
      test_directed();
      test_backpressure();
      test_random(18, 72, 170);
      test_random(72, 18, 170);
      test_random(0, 0, 170);

      if (n_errors == 0 && expected_runs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/rledec_pkg.sv
hdl/rledec_front.sv
hdl/rledec_queue.sv
hdl/dual_format_rle_decoder_core.sv
hdl/rledec_checker.sv
verif/testbench.sv
